### hdl/counting_semaphore_wait_queue_defines.svh
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CSW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define CSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/csw_pkg.sv
`timescale 1ns / 1ps

package csw_pkg;

   localparam int MAX_WAITERS    = 16;
   localparam int THREAD_ID_BITS = 8;

   localparam int PTR_BITS       = $clog2(MAX_WAITERS);
   localparam int WAIT_CNT_BITS  = $clog2(MAX_WAITERS + 1);
   localparam int REQ_DATA_BITS  = ((THREAD_ID_BITS + 7) / 8) * 8;
   localparam int RSP_ID_BITS    = 8;
   localparam int COUNT_BITS     = 18;
   localparam int INIT_BITS      = 16;
   localparam int REQ_TYPE_BITS  = 2;
   localparam int STATUS_BITS    = 4;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // request codes
   localparam logic [REQ_TYPE_BITS-1:0] REQ_WAIT   = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SIGNAL = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_TRY    = 2'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_CLOSE  = 2'd3;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_GRANTED     = 4'd0;
   localparam logic [STATUS_BITS-1:0] ST_BLOCKED     = 4'd1;
   localparam logic [STATUS_BITS-1:0] ST_WOKEN       = 4'd2;
   localparam logic [STATUS_BITS-1:0] ST_TRY_FAILED  = 4'd3;
   localparam logic [STATUS_BITS-1:0] ST_CLOSED_ERR  = 4'd4;
   localparam logic [STATUS_BITS-1:0] ST_CLOSE_DONE  = 4'd5;
   localparam logic [STATUS_BITS-1:0] ST_QUEUE_FULL  = 4'd6;
   localparam logic [STATUS_BITS-1:0] ST_SIGNAL_DONE = 4'd7;
   localparam logic [STATUS_BITS-1:0] ST_WOKEN_CLOSE = 4'd8;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WAIT,
      OP_TRY,
      OP_SIGNAL,
      OP_SIG_DONE,
      OP_CLOSE_STEP
   } op_type;

   typedef struct packed {
      logic   latch;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0] req_type;
      logic                     out_free;
      logic                     wake;
      logic                     has_waiters;
   } sts_type;

   function automatic logic [RSP_ID_BITS-1:0] to_rsp_id(
      input logic [THREAD_ID_BITS-1:0] id
   );
      logic [31:0] wide;
      wide = 32'(id);
      return wide[RSP_ID_BITS-1:0];
   endfunction

endpackage

### hdl/csw_ctrl.sv
`timescale 1ns / 1ps

module csw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  csw_pkg::sts_type sts,
   output csw_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SIG_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd.latch = req_tvalid && (state_ff == S_IDLE);
      cmd.op    = csw_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               case (sts.req_type)
                  csw_pkg::REQ_WAIT: begin
                     cmd.op   = csw_pkg::OP_WAIT;
                     state_in = S_IDLE;
                  end
                  csw_pkg::REQ_SIGNAL: begin
                     cmd.op   = csw_pkg::OP_SIGNAL;
                     state_in = sts.wake ? S_SIG_DONE : S_IDLE;
                  end
                  csw_pkg::REQ_TRY: begin
                     cmd.op   = csw_pkg::OP_TRY;
                     state_in = S_IDLE;
                  end
                  csw_pkg::REQ_CLOSE: begin
                     // stay here while waiters remain to be released
                     cmd.op   = csw_pkg::OP_CLOSE_STEP;
                     state_in = sts.has_waiters ? S_EXEC : S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SIG_DONE: begin
            if (sts.out_free) begin
               cmd.op   = csw_pkg::OP_SIG_DONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/csw_datapath.sv
`timescale 1ns / 1ps

module csw_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [csw_pkg::INIT_BITS-1:0]         csr_wr_data,
   input  logic [csw_pkg::REQ_TYPE_BITS-1:0]     req_type,
   input  logic [csw_pkg::THREAD_ID_BITS-1:0]    req_caller,
   input  csw_pkg::cmd_type                      cmd,
   output csw_pkg::sts_type                      sts,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [csw_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [csw_pkg::RSP_ID_BITS-1:0]       rsp_id,
   output logic                                  rsp_last
);

   logic signed [csw_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                                     closed_ff, closed_in;
   logic [csw_pkg::PTR_BITS-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [csw_pkg::PTR_BITS-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [csw_pkg::WAIT_CNT_BITS-1:0]        total_ff, total_in;
   logic [csw_pkg::REQ_TYPE_BITS-1:0]        req_type_ff;
   logic [csw_pkg::THREAD_ID_BITS-1:0]       caller_ff;
   logic [csw_pkg::THREAD_ID_BITS-1:0]       mem [csw_pkg::MAX_WAITERS];
   logic [csw_pkg::THREAD_ID_BITS-1:0]       rd_data_ff;
   logic                                     mem_we;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [csw_pkg::STATUS_BITS-1:0]          rsp_status_ff, rsp_status_in;
   logic [csw_pkg::RSP_ID_BITS-1:0]          rsp_id_ff, rsp_id_in;
   logic                                     rsp_last_ff, rsp_last_in;
   logic                                     emit;
   logic                                     count_pos;
   logic                                     count_max;
   logic                                     has_waiters;
   logic                                     queue_full;
   logic                                     wake;
   logic                                     out_free;

   function automatic logic [csw_pkg::PTR_BITS-1:0] advance(
      input logic [csw_pkg::PTR_BITS-1:0] p
   );
      return (p == csw_pkg::PTR_BITS'(csw_pkg::MAX_WAITERS - 1)) ? '0 : p + 1'b1;
   endfunction

   assign count_pos   = !count_ff[csw_pkg::COUNT_BITS-1] && (count_ff != '0);
   assign count_max   = (count_ff == csw_pkg::COUNT_MAX);
   assign has_waiters = (total_ff != '0);
   assign queue_full  = (total_ff == csw_pkg::WAIT_CNT_BITS'(csw_pkg::MAX_WAITERS));
   // outside a close, a negative count means waiters are queued; a close releases waiters without raising the count
   assign wake        = count_ff[csw_pkg::COUNT_BITS-1] && has_waiters;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   assign sts.req_type    = req_type_ff;
   assign sts.out_free    = out_free;
   assign sts.wake        = wake;
   assign sts.has_waiters = has_waiters;

   always_comb begin
      count_in      = count_ff;
      closed_in     = closed_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      total_in      = total_ff;
      mem_we        = 1'b0;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = csw_pkg::to_rsp_id(caller_ff);
      rsp_last_in   = 1'b1;
      case (cmd.op)
         csw_pkg::OP_WAIT: begin
            emit = 1'b1;
            if (closed_ff) begin
               rsp_status_in = csw_pkg::ST_CLOSED_ERR;
            end else if (count_pos) begin
               count_in      = count_ff - csw_pkg::COUNT_ONE;
               rsp_status_in = csw_pkg::ST_GRANTED;
            end else if (queue_full) begin
               rsp_status_in = csw_pkg::ST_QUEUE_FULL;
            end else begin
               count_in      = count_ff - csw_pkg::COUNT_ONE;
               mem_we        = 1'b1;
               wr_ptr_in     = advance(wr_ptr_ff);
               total_in      = total_ff + 1'b1;
               rsp_status_in = csw_pkg::ST_BLOCKED;
            end
         end
         csw_pkg::OP_TRY: begin
            emit = 1'b1;
            if (closed_ff) begin
               rsp_status_in = csw_pkg::ST_CLOSED_ERR;
            end else if (count_pos) begin
               count_in      = count_ff - csw_pkg::COUNT_ONE;
               rsp_status_in = csw_pkg::ST_GRANTED;
            end else begin
               rsp_status_in = csw_pkg::ST_TRY_FAILED;
            end
         end
         csw_pkg::OP_SIGNAL: begin
            emit = 1'b1;
            if (!count_max) begin
               count_in = count_ff + csw_pkg::COUNT_ONE;
            end
            if (wake) begin
               rd_ptr_in     = advance(rd_ptr_ff);
               total_in      = total_ff - 1'b1;
               rsp_status_in = csw_pkg::ST_WOKEN;
               rsp_id_in     = csw_pkg::to_rsp_id(rd_data_ff);
               rsp_last_in   = 1'b0;
            end else begin
               rsp_status_in = csw_pkg::ST_SIGNAL_DONE;
            end
         end
         csw_pkg::OP_SIG_DONE: begin
            emit          = 1'b1;
            rsp_status_in = csw_pkg::ST_SIGNAL_DONE;
         end
         csw_pkg::OP_CLOSE_STEP: begin
            emit      = 1'b1;
            closed_in = 1'b1;
            if (has_waiters) begin
               rd_ptr_in     = advance(rd_ptr_ff);
               total_in      = total_ff - 1'b1;
               rsp_status_in = csw_pkg::ST_WOKEN_CLOSE;
               rsp_id_in     = csw_pkg::to_rsp_id(rd_data_ff);
               rsp_last_in   = 1'b0;
            end else begin
               if (!count_pos) begin
                  count_in = csw_pkg::COUNT_ONE;
               end
               rsp_status_in = csw_pkg::ST_CLOSE_DONE;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      // a register write re-creates the semaphore
      if (csr_wr_en) begin
         count_in  = csw_pkg::COUNT_BITS'(csr_wr_data);
         closed_in = 1'b0;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         total_in  = '0;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_type_ff <= req_type;
         caller_ff   <= req_caller;
      end
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // queue storage; read ahead at the next head so a drain runs every cycle while the response output is free
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= caller_ff;
      end
      rd_data_ff <= mem[rd_ptr_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### hdl/counting_semaphore_wait_queue.sv
// A taken request is latched into the datapath request registers; in S_EXEC the state machine
// then issues its first response into the output register once that register is free.
// A signal that wakes a waiter adds a response from S_SIG_DONE, and a close stays in S_EXEC
// while waiters remain; the state machine handles one request at a time.
// Reset is synchronous and active high: the count loads 0, the queue empties, closed clears.
`timescale 1ns / 1ps
`include "counting_semaphore_wait_queue_defines.svh"

module counting_semaphore_wait_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [csw_pkg::INIT_BITS-1:0]         csr_wr_data,    // initial_count
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [csw_pkg::REQ_DATA_BITS-1:0]     req_tdata,      // caller_id
   input  logic [csw_pkg::REQ_TYPE_BITS-1:0]     req_tuser,      // req_type
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [csw_pkg::RSP_ID_BITS-1:0]       rsp_tdata,      // thread_id
   output logic [csw_pkg::STATUS_BITS-1:0]       rsp_tuser,      // status
   output logic                                  rsp_tlast
);

   csw_pkg::cmd_type cmd;
   csw_pkg::sts_type sts;

   csw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   csw_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_type    (req_tuser),
      .req_caller  (req_tdata[csw_pkg::THREAD_ID_BITS-1:0]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_id      (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

   `CSW_ASSERT_NEXT(a_one_request_at_a_time, req_tvalid && req_tready, !req_tready, "busy take")
   `CSW_ASSERT_NOW(a_partial_blocks_input, rsp_tvalid && !rsp_tlast, !req_tready, "input open")
   `CSW_ASSERT_NOW(a_woken_not_last, rsp_tvalid && (rsp_tuser == csw_pkg::ST_WOKEN), !rsp_tlast, "woken last")

endmodule
